/* rtl/core/rdc_pkg.sv */
package rdc_pkg;

    // width of the number that is converted
    localparam int VALUE_BITS = 31;

    // quotient bits resolved per cycle by the shared compare-subtract unit
    localparam int STEP_BITS  = 4;
    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int QUO_BITS   = DIV_CYCLES * STEP_BITS;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // digit store index, also used for digit counts minus one
    localparam int IDX_W = $clog2(VALUE_BITS);

    // digit, radix and character widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
    localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] CHAR_Z    = CHAR_W'(90);

    // configuration register port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEAST_FIRST = CFG_IDX_W'(1);

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    // digit value to ascii character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else begin
            ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return ch;
    endfunction

endpackage

/* rtl/core/radix_digit_converter.sv */
// radix_digit_converter
//
// Converts a non-negative integer to its digits in a base from 2 to 36 and
// sends them out one ascii character per word ('0'-'9', then 'A'-'Z').
// Input: pulse start with i_value while busy is low; the number is taken at
// that edge and busy stays high until its last digit has been handed to the
// output register. Output: o_digit_valid is high for exactly one cycle per
// digit, with o_digit_char and o_last_digit set on the final digit. The
// receiver cannot stall; digits of one number come out on back-to-back
// cycles. Zero gives the single word '0'.
// Config: i_cfg_valid/o_cfg_ready write register i_cfg_index (0 = radix,
// 1 = least-first order); o_cfg_ready is always high, write only while idle.
// Sequence for a number of n digits: each digit is worked out in turn by the
// shared 4-bit-per-cycle compare-subtract divider, then the n digits leave at
// one per cycle. A new number is taken only once the last digit has been
// handed to the output register.
// Reset (synchronous, active low) returns to idle with radix 10 and most
// significant digit first; the digit store is not cleared.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_digit_valid,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last_digit
);

    t_state r_state, n_state;

    logic [RADIX_W-1:0]  r_radix;
    logic                r_least_first;

    logic [QUO_BITS-1:0] r_quo, n_quo;
    logic [RADIX_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [IDX_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_left, n_left;
    logic [RADIX_W-1:0]  r_store [VALUE_BITS];

    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    logic [RADIX_W-1:0]  eff_radix;
    logic [QUO_BITS-1:0] div_quo;
    logic [RADIX_W-1:0]  div_rem;
    logic                div_last;
    logic                div_end;
    logic                store_we;

    // radix register clamped to the legal range
    always_comb begin
        priority if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // shared divider: STEP_BITS restoring compare-subtract steps per cycle
    always_comb begin
        logic [RADIX_W:0]    rem_w;
        logic [QUO_BITS-1:0] quo_w;
        rem_w = {1'b0, r_rem};
        quo_w = r_quo;
        for (int i = 0; i < STEP_BITS; i++) begin
            rem_w = {rem_w[RADIX_W-1:0], quo_w[QUO_BITS-1]};
            quo_w = {quo_w[QUO_BITS-2:0], 1'b0};
            if (rem_w >= {1'b0, eff_radix}) begin
                rem_w    = rem_w - {1'b0, eff_radix};
                quo_w[0] = 1'b1;
            end
        end
        div_quo = quo_w;
        div_rem = rem_w[RADIX_W-1:0];
    end

    assign div_last = (r_step == STEP_W'(DIV_CYCLES - 1));
    assign div_end  = div_last &&
                      ((div_quo == '0) || (r_count == IDX_W'(VALUE_BITS - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_left == '0) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath and output values
    always_comb begin
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_out_valid = 1'b0;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        store_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_quo   = QUO_BITS'(i_value);
                    n_rem   = '0;
                    n_step  = '0;
                    n_count = '0;
                end
            end
            S_DIV: begin
                n_quo  = div_quo;
                n_rem  = div_rem;
                n_step = r_step + STEP_W'(1);
                if (div_last) begin
                    store_we = 1'b1;
                    n_rem    = '0;
                    n_step   = '0;
                    n_count  = r_count + IDX_W'(1);
                    n_pos    = r_least_first ? '0 : r_count;
                    n_left   = r_count;
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_char  = digit_to_ascii(r_store[r_pos]);
                n_out_last  = (r_left == '0);
                n_pos       = r_least_first ? (r_pos + IDX_W'(1)) : (r_pos - IDX_W'(1));
                n_left      = r_left - IDX_W'(1);
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_radix       <= RADIX_RESET;
            r_least_first <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                priority if (i_cfg_index == CFG_RADIX) begin
                    r_radix <= i_cfg_data[RADIX_W-1:0];
                end else if (i_cfg_index == CFG_LEAST_FIRST) begin
                    r_least_first <= i_cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_count    <= n_count;
        r_pos      <= n_pos;
        r_left     <= n_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count] <= div_rem;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_digit_valid = r_out_valid;
    assign o_digit_char  = r_out_char;
    assign o_last_digit  = r_out_last;

endmodule

/* rtl/core/rdc_checker.sv */
module rdc_checker
    import rdc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [VALUE_BITS-1:0] i_value,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  o_digit_valid,
    input logic [CHAR_W-1:0]     o_digit_char,
    input logic                  o_last_digit
);

    // a digit word only follows a busy cycle
    a_digit_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> $past(busy))
        else $error("digit word without a busy cycle before it");

    // an accepted number starts a conversion with no word in the next cycle
    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_digit_valid))
        else $error("accepted number did not start a conversion");

    // digits of one number leave on consecutive cycles
    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_valid && !o_last_digit) |=> o_digit_valid)
        else $error("gap inside the digits of one number");

    // nothing follows the last digit directly
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_valid && o_last_digit) |=> !o_digit_valid)
        else $error("word right after the last digit");

    // characters are digits or capital letters
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |->
            ((o_digit_char >= CHAR_ZERO && o_digit_char <= CHAR_NINE) ||
             (o_digit_char >= CHAR_A && o_digit_char <= CHAR_Z)))
        else $error("digit character out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
